// ===== rtl/prd_pkg.sv =====
// Shared types and constants for the PGS run-length run decoder.
// No dependencies; the interfaces and the top level import this package.
package prd_pkg;

   localparam int ByteWidth     = 8;
   localparam int CoordWidth    = 16;
   localparam int LengthWidth   = 14;
   localparam int CsrIndexWidth = 4;
   localparam int CsrDataWidth  = 16;

   // Register indexes of the configuration channel
   typedef enum logic [CsrIndexWidth-1:0] {
      CsrXOffset       = 4'd0,
      CsrYOffset       = 4'd1,
      CsrLineLimit     = 4'd2,
      CsrPictureHeight = 4'd3
   } csr_index_type;

   // Top two bits of the first escape byte: length size and colour presence
   typedef enum logic [1:0] {
      LenShortImplied = 2'b00,
      LenLongImplied  = 2'b01,
      LenShortColour  = 2'b10,
      LenLongColour   = 2'b11
   } len_mode_type;

   localparam logic [5:0] ShortLenMask = 6'h3f;

   typedef struct packed {
      logic [ByteWidth-1:0] rle_byte;
      logic                 object_start;
   } req_type;

   typedef struct packed {
      logic [ByteWidth-1:0]   palette_index;
      logic [CoordWidth-1:0]  run_start;
      logic [LengthWidth-1:0] run_length;
      logic [CoordWidth-1:0]  row;
      logic                   end_of_line;
   } rsp_type;

   typedef struct packed {
      logic [CsrIndexWidth-1:0] index;
      logic [CsrDataWidth-1:0]  data;
   } csr_type;

endpackage

// ===== rtl/prd_if.sv =====
// Valid/ready channel interfaces for the run decoder: request, result, register write.
// Depends on prd_pkg for the payload structs.
interface prd_req_if;
   import prd_pkg::*;
   logic    valid;
   logic    ready;
   req_type payload;
   modport source (output valid, output payload, input ready);
   modport sink   (input valid, input payload, output ready);
endinterface

interface prd_rsp_if;
   import prd_pkg::*;
   logic    valid;
   logic    ready;
   rsp_type payload;
   modport source (output valid, output payload, input ready);
   modport sink   (input valid, input payload, output ready);
endinterface

interface prd_csr_if;
   import prd_pkg::*;
   logic    valid;
   logic    ready;
   csr_type payload;
   modport source (output valid, output payload, input ready);
   modport sink   (input valid, input payload, output ready);
endinterface

// ===== rtl/pgs_rle_run_decoder.sv =====
// Each run is registered into the result buffer head (out_ff), or into skid_ff while the head is stalled.
// One request per cycle while req_bus.ready is high; each byte is decoded in the cycle it is accepted.
// Results go through a two-entry buffer; req_bus.ready drops only while both are full.
// Register writes are taken every cycle (csr_bus.ready is always high).
// Reset (synchronous): decoder stopped, result buffer empty, registers and state zero.
// Depends on prd_pkg and the channel interfaces in prd_if.sv.
module pgs_rle_run_decoder (
   input  logic      clock,
   input  logic      reset,
   prd_req_if.sink   req_bus,
   prd_rsp_if.source rsp_bus,
   prd_csr_if.sink   csr_bus
);
   import prd_pkg::*;

   typedef enum logic [2:0] {
      PhStopped,
      PhHdr1,
      PhHdr2,
      PhHdr3,
      PhCode,
      PhLen1,
      PhLen2,
      PhColour
   } phase_type;

   phase_type              phase_ff, phase_in;
   logic [CoordWidth-1:0]  width_ff, width_in;
   logic [LengthWidth-1:0] held_ff, held_in;
   logic                   colour_follows_ff, colour_follows_in;
   logic [CoordWidth-1:0]  left_edge_ff, left_edge_in;
   logic [CoordWidth-1:0]  right_edge_ff, right_edge_in;
   logic [CoordWidth-1:0]  x_ff, x_in;
   logic [CoordWidth-1:0]  row_ff, row_in;

   logic [CoordWidth-1:0]  x_offset_ff, y_offset_ff, line_limit_ff, height_ff;

   rsp_type                out_ff, skid_ff;
   logic                   out_valid_ff, skid_valid_ff;

   logic                   accept, pop, push;
   logic [ByteWidth-1:0]   byte_in;
   len_mode_type           len_mode;
   logic                   emit_en;
   logic [ByteWidth-1:0]   emit_colour;
   logic [LengthWidth-1:0] emit_len;
   logic [CoordWidth-1:0]  room;
   logic [LengthWidth-1:0] clip_len;
   logic                   eol;
   logic [CoordWidth:0]    row_inc;
   logic [CoordWidth:0]    right_sum;
   rsp_type                run;

   assign req_bus.ready   = !skid_valid_ff;
   assign csr_bus.ready   = 1'b1;
   assign rsp_bus.valid   = out_valid_ff;
   assign rsp_bus.payload = out_ff;

   assign accept   = req_bus.valid && req_bus.ready;
   assign pop      = out_valid_ff && rsp_bus.ready;
   assign byte_in  = req_bus.payload.rle_byte;
   assign len_mode = len_mode_type'(byte_in[7:6]);

   // Colour and raw length of the run that this byte would complete
   always_comb begin
      emit_en     = 1'b0;
      emit_colour = '0;
      emit_len    = '0;
      case (phase_ff)
         PhCode: begin
            emit_en     = (byte_in != '0);
            emit_colour = byte_in;
            emit_len    = LengthWidth'(1);
         end
         PhLen1: begin
            emit_en  = (len_mode == LenShortImplied);
            emit_len = {{(LengthWidth-6){1'b0}}, byte_in[5:0] & ShortLenMask};
         end
         PhLen2: begin
            emit_en  = !colour_follows_ff;
            emit_len = held_ff | {{(LengthWidth-ByteWidth){1'b0}}, byte_in};
         end
         PhColour: begin
            emit_en     = 1'b1;
            emit_colour = byte_in;
            emit_len    = held_ff;
         end
         default: begin
            emit_en = 1'b0;
         end
      endcase
   end

   assign room      = (right_edge_ff >= x_ff) ? right_edge_ff - x_ff : '0;
   assign clip_len  = ({{(CoordWidth-LengthWidth){1'b0}}, emit_len} > room)
                      ? room[LengthWidth-1:0] : emit_len;
   assign eol       = (clip_len == '0);
   assign row_inc   = {1'b0, row_ff} + {{CoordWidth{1'b0}}, 1'b1};
   assign right_sum = {1'b0, x_offset_ff} + {1'b0, width_ff};
   assign push      = accept && !req_bus.payload.object_start && emit_en;

   always_comb begin
      run.palette_index = emit_colour;
      run.run_start     = x_ff;
      run.run_length    = clip_len;
      run.row           = row_ff;
      run.end_of_line   = eol;
   end

   always_comb begin
      phase_in          = phase_ff;
      width_in          = width_ff;
      held_in           = held_ff;
      colour_follows_in = colour_follows_ff;
      left_edge_in      = left_edge_ff;
      right_edge_in     = right_edge_ff;
      x_in              = x_ff;
      row_in            = row_ff;
      if (accept) begin
         if (req_bus.payload.object_start) begin
            // restart wins over anything in flight
            width_in = {byte_in, width_ff[7:0]};
            phase_in = PhHdr1;
         end else begin
            case (phase_ff)
               PhHdr1: begin
                  width_in = {width_ff[15:8], byte_in};
                  phase_in = PhHdr2;
               end
               PhHdr2: begin
                  phase_in = PhHdr3;
               end
               PhHdr3: begin
                  left_edge_in  = (x_offset_ff < line_limit_ff) ? x_offset_ff : line_limit_ff;
                  x_in          = left_edge_in;
                  right_edge_in = (right_sum < {1'b0, line_limit_ff})
                                  ? right_sum[CoordWidth-1:0] : line_limit_ff;
                  row_in        = (y_offset_ff < height_ff) ? y_offset_ff : height_ff;
                  phase_in      = PhCode;
               end
               PhCode: begin
                  if (byte_in == '0) begin
                     phase_in = PhLen1;
                  end
               end
               PhLen1: begin
                  case (len_mode)
                     LenShortImplied: begin
                        phase_in = PhCode;
                     end
                     LenLongImplied: begin
                        held_in           = {byte_in[5:0], 8'h00};
                        colour_follows_in = 1'b0;
                        phase_in          = PhLen2;
                     end
                     LenShortColour: begin
                        held_in           = {8'h00, byte_in[5:0]};
                        colour_follows_in = 1'b1;
                        phase_in          = PhColour;
                     end
                     default: begin
                        held_in           = {byte_in[5:0], 8'h00};
                        colour_follows_in = 1'b1;
                        phase_in          = PhLen2;
                     end
                  endcase
               end
               PhLen2: begin
                  held_in  = emit_len;
                  phase_in = colour_follows_ff ? PhColour : PhCode;
               end
               PhColour: begin
                  phase_in = PhCode;
               end
               default: begin
                  phase_in = phase_ff;
               end
            endcase
            if (emit_en) begin
               x_in = x_ff + {{(CoordWidth-LengthWidth){1'b0}}, clip_len};
               if (eol) begin
                  x_in   = left_edge_ff;
                  row_in = row_inc[CoordWidth-1:0];
                  if (row_inc >= {1'b0, height_ff}) begin
                     phase_in = PhStopped;
                  end
               end
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff          <= PhStopped;
         width_ff          <= '0;
         held_ff           <= '0;
         colour_follows_ff <= 1'b0;
         left_edge_ff      <= '0;
         right_edge_ff     <= '0;
         x_ff              <= '0;
         row_ff            <= '0;
         x_offset_ff       <= '0;
         y_offset_ff       <= '0;
         line_limit_ff     <= '0;
         height_ff         <= '0;
         out_valid_ff      <= 1'b0;
         skid_valid_ff     <= 1'b0;
      end else begin
         phase_ff          <= phase_in;
         width_ff          <= width_in;
         held_ff           <= held_in;
         colour_follows_ff <= colour_follows_in;
         left_edge_ff      <= left_edge_in;
         right_edge_ff     <= right_edge_in;
         x_ff              <= x_in;
         row_ff            <= row_in;
         if (csr_bus.valid) begin
            case (csr_index_type'(csr_bus.payload.index))
               CsrXOffset:       x_offset_ff   <= csr_bus.payload.data;
               CsrYOffset:       y_offset_ff   <= csr_bus.payload.data;
               CsrLineLimit:     line_limit_ff <= csr_bus.payload.data;
               CsrPictureHeight: height_ff     <= csr_bus.payload.data;
               default: begin
               end
            endcase
         end
         // two-entry result buffer; no push can arrive while the skid is full
         if (skid_valid_ff) begin
            if (pop) begin
               skid_valid_ff <= 1'b0;
            end
         end else if (push) begin
            if (out_valid_ff && !pop) begin
               skid_valid_ff <= 1'b1;
            end else begin
               out_valid_ff <= 1'b1;
            end
         end else if (pop) begin
            out_valid_ff <= 1'b0;
         end
      end
   end

   // result payloads, no reset needed
   always_ff @(posedge clock) begin
      if (skid_valid_ff) begin
         if (pop) begin
            out_ff <= skid_ff;
         end
      end else if (push) begin
         if (out_valid_ff && !pop) begin
            skid_ff <= run;
         end else begin
            out_ff <= run;
         end
      end
   end

`ifndef NO_ASSERTIONS
   a_skid_implies_head: assert property (@(posedge clock) disable iff (reset)
      skid_valid_ff |-> out_valid_ff)
      else $error("skid entry held with empty head");

   a_stall_fills_skid: assert property (@(posedge clock) disable iff (reset)
      (push && out_valid_ff && !pop) |=> skid_valid_ff)
      else $error("stalled run was not kept in skid");

   a_eol_matches_len: assert property (@(posedge clock) disable iff (reset)
      out_valid_ff |-> (out_ff.end_of_line == (out_ff.run_length == '0)))
      else $error("end_of_line disagrees with run_length");

   a_stopped_silent: assert property (@(posedge clock) disable iff (reset)
      (phase_ff == PhStopped) |-> !push)
      else $error("run emitted while stopped");

   a_eol_moves_row: assert property (@(posedge clock) disable iff (reset)
      (push && eol) |=> (row_ff == $past(row_inc[CoordWidth-1:0]) && x_ff == left_edge_ff))
      else $error("line end did not advance row");
`endif

endmodule

// ===== tb/pgs_rle_run_decoder_tb.sv =====
// Self-checking testbench for pgs_rle_run_decoder: random and directed RLE objects,
// an in-bench decoder that predicts every run, and random idling on both channels.
// Depends on prd_pkg, the channel interfaces in prd_if.sv and the decoder RTL.
module pgs_rle_run_decoder_tb;
   timeunit 1ns;
   timeprecision 1ps;
   import prd_pkg::*;

   typedef enum logic [3:0] {
      DecIdle, DecWidthLo, DecHeightHi, DecHeightLo, DecCode, DecLen1, DecLen2, DecColour
   } dec_phase_type;

   logic clock = 1'b0;
   logic reset = 1'b1;

   prd_req_if req_bus ();
   prd_rsp_if rsp_bus ();
   prd_csr_if csr_bus ();

   pgs_rle_run_decoder u_dut (
      .clock   (clock),
      .reset   (reset),
      .req_bus (req_bus),
      .rsp_bus (rsp_bus),
      .csr_bus (csr_bus)
   );

   always begin
      #10 clock = 1'b1;
      #10 clock = 1'b0;
   end

   // Decoder registers and state as the block should hold them
   logic [15:0]   cfg_x_offset = '0;
   logic [15:0]   cfg_y_offset = '0;
   logic [15:0]   cfg_line_limit = '0;
   logic [15:0]   cfg_picture_height = '0;
   dec_phase_type dec_phase = DecIdle;
   logic [15:0]   obj_width = '0;
   logic [13:0]   held_length = '0;
   logic          colour_follows = 1'b0;
   logic [15:0]   left_edge = '0;
   logic [15:0]   right_edge = '0;
   logic [15:0]   x_pos = '0;
   logic [15:0]   row_pos = '0;

   req_type pending_requests [$];
   rsp_type runs_expected [$];
   int      requests_queued = 0;
   int      requests_accepted = 0;
   int      planned = 0;
   int      mismatches = 0;
   int      gap_left = 0;
   int      stall_left = 0;
   bit      drv_calm = 1'b0;
   bit      mon_calm = 1'b0;

   task automatic push_run(input logic [7:0] colour, input logic [13:0] length);
      logic [16:0] room;
      logic [16:0] next_row;
      logic [13:0] len;
      rsp_type     run;
      room = ({1'b0, right_edge} >= {1'b0, x_pos}) ? {1'b0, right_edge} - {1'b0, x_pos} : '0;
      len = length;
      if ({3'b000, len} > room) len = room[13:0];
      run.palette_index = colour;
      run.run_start     = x_pos;
      run.run_length    = len;
      run.row           = row_pos;
      run.end_of_line   = (len == 0);
      runs_expected.push_back(run);
      x_pos = x_pos + {2'b00, len};
      if (len == 0) begin
         next_row = {1'b0, row_pos} + 17'd1;
         x_pos = left_edge;
         if (next_row >= {1'b0, cfg_picture_height}) dec_phase = DecIdle;
         row_pos = next_row[15:0];
      end
   endtask

   task automatic decode_byte(input req_type item);
      logic [7:0]  b;
      logic [16:0] far_edge;
      b = item.rle_byte;
      if (item.object_start) begin
         obj_width = {b, 8'h00};
         dec_phase = DecWidthLo;
      end else begin
         case (dec_phase)
            DecWidthLo: begin
               obj_width[7:0] = b;
               dec_phase = DecHeightHi;
            end
            DecHeightHi: dec_phase = DecHeightLo;
            DecHeightLo: begin
               left_edge = (cfg_x_offset < cfg_line_limit) ? cfg_x_offset : cfg_line_limit;
               far_edge = {1'b0, cfg_x_offset} + {1'b0, obj_width};
               right_edge = (far_edge < {1'b0, cfg_line_limit}) ? far_edge[15:0] : cfg_line_limit;
               x_pos = left_edge;
               row_pos = (cfg_y_offset < cfg_picture_height) ? cfg_y_offset : cfg_picture_height;
               dec_phase = DecCode;
            end
            DecCode: begin
               if (b != 0) push_run(b, 14'd1);
               else dec_phase = DecLen1;
            end
            DecLen1: begin
               case (len_mode_type'(b[7:6]))
                  LenShortImplied: begin
                     dec_phase = DecCode;
                     push_run(8'h00, {8'h00, b[5:0] & ShortLenMask});
                  end
                  LenLongImplied: begin
                     held_length = {b[5:0], 8'h00};
                     colour_follows = 1'b0;
                     dec_phase = DecLen2;
                  end
                  LenShortColour: begin
                     held_length = {8'h00, b[5:0]};
                     colour_follows = 1'b1;
                     dec_phase = DecColour;
                  end
                  default: begin
                     held_length = {b[5:0], 8'h00};
                     colour_follows = 1'b1;
                     dec_phase = DecLen2;
                  end
               endcase
            end
            DecLen2: begin
               held_length = held_length | {6'h00, b};
               if (colour_follows) begin
                  dec_phase = DecColour;
               end else begin
                  dec_phase = DecCode;
                  push_run(8'h00, held_length);
               end
            end
            DecColour: begin
               dec_phase = DecCode;
               push_run(b, held_length);
            end
            default: ;
         endcase
      end
   endtask

   function automatic int idle_length(input bit calm);
      int r;
      r = $urandom_range(0, 99);
      if (calm || r < 55) return 0;
      if (r < 90) return $urandom_range(1, 3);
      return $urandom_range(6, 30);
   endfunction

   task automatic check_run(input rsp_type got);
      rsp_type want;
      if (runs_expected.size() == 0) begin
         mismatches++;
         $display("%0t: unexpected run, got %p", $time, got);
      end else begin
         want = runs_expected.pop_front();
         if (got.palette_index !== want.palette_index) begin
            mismatches++;
            $display("%0t: palette_index expected %0d, got %0d", $time,
                     want.palette_index, got.palette_index);
         end
         if (got.run_start !== want.run_start) begin
            mismatches++;
            $display("%0t: run_start expected %0d, got %0d", $time,
                     want.run_start, got.run_start);
         end
         if (got.run_length !== want.run_length) begin
            mismatches++;
            $display("%0t: run_length expected %0d, got %0d", $time,
                     want.run_length, got.run_length);
         end
         if (got.row !== want.row) begin
            mismatches++;
            $display("%0t: row expected %0d, got %0d", $time, want.row, got.row);
         end
         if (got.end_of_line !== want.end_of_line) begin
            mismatches++;
            $display("%0t: end_of_line expected %0b, got %0b", $time,
                     want.end_of_line, got.end_of_line);
         end
      end
   endtask

   // Request driver: holds a request until accepted, then waits out a random gap
   always @(posedge clock) begin
      if (reset) begin
         req_bus.valid <= 1'b0;
         gap_left = 0;
      end else begin
         if (req_bus.valid && req_bus.ready) begin
            decode_byte(req_bus.payload);
            requests_accepted++;
         end
         if (!(req_bus.valid && !req_bus.ready)) begin
            if (gap_left > 0) begin
               gap_left--;
               req_bus.valid <= 1'b0;
            end else if (pending_requests.size() > 0) begin
               req_bus.payload <= pending_requests.pop_front();
               req_bus.valid <= 1'b1;
               if ($urandom_range(0, 63) == 0) drv_calm = !drv_calm;
               gap_left = idle_length(drv_calm);
            end else begin
               req_bus.valid <= 1'b0;
            end
         end
      end
   end

   // Result monitor with random back-pressure
   always @(posedge clock) begin
      if (reset) begin
         rsp_bus.ready <= 1'b0;
         stall_left = 0;
      end else begin
         if (rsp_bus.valid && rsp_bus.ready) check_run(rsp_bus.payload);
         if ($urandom_range(0, 63) == 0) mon_calm = !mon_calm;
         if (stall_left > 0) begin
            stall_left--;
            rsp_bus.ready <= 1'b0;
         end else begin
            rsp_bus.ready <= 1'b1;
            stall_left = idle_length(mon_calm);
         end
      end
   end

   task automatic push_item(input logic [7:0] data, input logic start, input bit counted = 1'b1);
      req_type item;
      item.rle_byte = data;
      item.object_start = start;
      pending_requests.push_back(item);
      requests_queued++;
      if (counted) planned++;
   endtask

   task automatic gen_object(input int n_codes);
      logic [15:0]  w;
      logic [13:0]  len;
      len_mode_type mode;
      int           pick;
      pick = $urandom_range(0, 9);
      w = (pick == 0) ? 16'h0000 : (pick == 1) ? 16'($urandom) : 16'($urandom_range(1, 48));
      push_item(w[15:8], 1'b1);
      push_item(w[7:0], 1'b0);
      push_item(8'($urandom), 1'b0);
      push_item(8'($urandom), 1'b0);
      for (int k = 0; k < n_codes; k++) begin
         pick = $urandom_range(0, 99);
         len = ($urandom_range(0, 3) == 0) ? 14'($urandom) : 14'($urandom_range(0, 20));
         mode = len_mode_type'($urandom_range(0, 3));
         if (pick < 2) begin
            push_item(8'($urandom), 1'b1);          // restart in the middle of an object
         end else if (pick < 5) begin
            push_item(8'($urandom), 1'b0);          // stray byte
         end else if (pick < 50) begin
            push_item(8'($urandom_range(1, 255)), 1'b0);
         end else if (pick < 60) begin
            push_item(8'h00, 1'b0);
            push_item({LenShortImplied, 6'd0}, 1'b0);
         end else begin
            push_item(8'h00, 1'b0);
            case (mode)
               LenShortImplied: push_item({mode, len[5:0]}, 1'b0);
               LenShortColour: begin
                  push_item({mode, len[5:0]}, 1'b0);
                  push_item(8'($urandom), 1'b0);
               end
               LenLongImplied: begin
                  push_item({mode, len[13:8]}, 1'b0);
                  push_item(len[7:0], 1'b0);
               end
               default: begin
                  push_item({mode, len[13:8]}, 1'b0);
                  push_item(len[7:0], 1'b0);
                  push_item(8'($urandom), 1'b0);
               end
            endcase
         end
      end
      // trailing bytes, mostly dropped by a stopped decoder
      if ($urandom_range(0, 3) == 0)
         repeat ($urandom_range(1, 3)) push_item(8'($urandom), 1'b0, 1'b0);
   endtask

   task automatic random_objects(input int n_items);
      int target;
      target = planned + n_items;
      while (planned < target) gen_object($urandom_range(5, 40));
   endtask

   task automatic drain();
      while (requests_accepted != requests_queued || runs_expected.size() != 0)
         @(posedge clock);
      // a trailing request with no run may still be in the decoder
      repeat (4) @(posedge clock);
   endtask

   task automatic write_reg(input csr_index_type idx, input logic [15:0] value);
      @(posedge clock);
      csr_bus.payload <= {idx, value};
      csr_bus.valid <= 1'b1;
      do @(posedge clock); while (!csr_bus.ready);
      case (idx)
         CsrXOffset:       cfg_x_offset = value;
         CsrYOffset:       cfg_y_offset = value;
         CsrLineLimit:     cfg_line_limit = value;
         CsrPictureHeight: cfg_picture_height = value;
         default: ;
      endcase
      csr_bus.valid <= 1'b0;
   endtask

   task automatic configure(input logic [15:0] xo, input logic [15:0] yo,
                            input logic [15:0] ll, input logic [15:0] ph);
      drain();
      write_reg(CsrXOffset, xo);
      write_reg(CsrYOffset, yo);
      write_reg(CsrLineLimit, ll);
      write_reg(CsrPictureHeight, ph);
   endtask

   initial begin
      logic [15:0] yo;
      req_bus.valid = 1'b0;
      req_bus.payload = '0;
      rsp_bus.ready = 1'b0;
      csr_bus.valid = 1'b0;
      csr_bus.payload = '0;
      repeat (3) @(posedge clock);
      reset <= 1'b0;

      // left edge 5, right edge 13, first row 2
      configure(16'd5, 16'd2, 16'd40, 16'd10);
      push_item(8'h11, 1'b0);                        // dropped while stopped
      push_item(8'h00, 1'b1);
      push_item(8'h08, 1'b0);
      push_item(8'hff, 1'b0);
      push_item(8'hff, 1'b0);
      push_item(8'hff, 1'b0);
      push_item(8'h01, 1'b0);
      push_item(8'h00, 1'b0);
      push_item({LenShortImplied, 6'd5}, 1'b0);
      push_item(8'h00, 1'b0);                        // longest run, clipped at the edge
      push_item({LenLongColour, 6'h3f}, 1'b0);
      push_item(8'hff, 1'b0);
      push_item(8'h80, 1'b0);
      push_item(8'h7f, 1'b0);                        // starts on the right edge
      push_item(8'h00, 1'b0);
      push_item({LenShortColour, 6'd2}, 1'b0);
      push_item(8'haa, 1'b0);
      push_item(8'h00, 1'b0);
      push_item({LenLongImplied, 6'd0}, 1'b0);
      push_item(8'h03, 1'b0);
      push_item(8'h00, 1'b0);
      push_item({LenShortImplied, 6'd0}, 1'b0);
      push_item(8'h00, 1'b0);                        // escape cut off by a new object
      push_item(8'h00, 1'b1);
      push_item(8'h30, 1'b0);
      push_item(8'h00, 1'b0);
      push_item(8'h00, 1'b0);
      random_objects(150);

      configure(16'd0, 16'd0, 16'hffff, 16'hffff);
      random_objects(200);
      // right edge overflows past 16 bits; row wraps after the first line
      configure(16'hffff, 16'hffff, 16'hffff, 16'hffff);
      random_objects(60);
      // left edge clipped to the line limit
      configure(16'd30, 16'd100, 16'd20, 16'd120);
      random_objects(90);
      // first line decoded at picture height zero
      configure(16'd100, 16'd10, 16'hffff, 16'd0);
      random_objects(60);
      repeat (6) begin
         yo = 16'($urandom_range(0, 40));
         configure(($urandom_range(0, 3) == 0) ? 16'($urandom) : 16'($urandom_range(0, 60)),
                   yo,
                   ($urandom_range(0, 4) == 0) ? 16'($urandom) : 16'($urandom_range(0, 120)),
                   ($urandom_range(0, 5) == 0) ? 16'($urandom)
                                               : yo + 16'($urandom_range(0, 80)));
         random_objects(75);
      end

      drain();
      if (mismatches == 0) begin
         $display("SUCCESS");
      end else begin
         $display("FAILURE");
      end
      $finish;
   end

   initial begin
      #10_000_000;
      $display("FAILURE");
      $finish;
   end

endmodule
